FILE: src/utf8fs_pkg.sv
package utf8fs_pkg;

    localparam int MAX_FIELD_BYTES = 256;

    localparam logic [7:0] SEP_BYTE   = 8'h7C;  // '|'
    localparam logic [7:0] ONE_BYTE   = 8'h31;  // '1'
    localparam logic [7:0] ZERO_BYTE  = 8'h30;  // '0'
    localparam logic [7:0] NINE_BYTE  = 8'h39;  // '9'

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [16:0] MAX_BYTES_W = 17'(MAX_FIELD_BYTES);

    typedef struct packed {
        logic [7:0]  field_number;
        logic [7:0]  kept_length;
        logic        starts_with_one;
        logic        number_valid;
        logic [31:0] number_value;
        logic        last_field;
    } result_t;

    function automatic logic is_close(input logic [7:0] b, input logic eot);
        return eot || (b == SEP_BYTE);
    endfunction

    // byte limit of a field: min(capacity, max) - 1 (0 stays 0), saturated to 255
    function automatic logic [7:0] cap_to_limit(input logic [8:0] cap);
        logic [16:0] c;
        c = {8'd0, cap};
        if (c > MAX_BYTES_W)
        begin
            c = MAX_BYTES_W;
        end
        c = (c == 17'd0) ? 17'd0 : c - 17'd1;
        return (c > 17'd255) ? 8'hFF : c[7:0];
    endfunction

endpackage

FILE: src/utf8_safe_field_splitter_core.sv
// channel | signals                                   | payload
// input   | byte_valid / byte_ready                   | data_byte, end_of_text, capacity
// output  | field_valid / field_ready                 | field_number .. last_field
//
// one item per cycle sustained while the output has space for closing items;
// an accepted item is evaluated from the input register, and a closing item
// loads the result register once the output has space, so field_valid rises
// after the input register and then the result register have loaded
// the field state update is one combinational step per item, which sets the rate
// rst_n clears all field state and both valid flags asynchronously
// a stalled output only holds back separators and end markers; ordinary
// bytes keep flowing while a result waits
module utf8_safe_field_splitter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_text,
    input  logic [8:0]  capacity,
    output logic        field_valid,
    input  logic        field_ready,
    output logic [7:0]  field_number,
    output logic [7:0]  kept_length,
    output logic        starts_with_one,
    output logic        number_valid,
    output logic [31:0] number_value,
    output logic        last_field
);
    import utf8fs_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;
    logic [8:0] in_cap_reg;

    logic       closing;
    logic       out_space;
    logic       advance;
    logic       take;
    result_t    scan_result;
    result_t    out_data;

    assign closing    = is_close(in_byte_reg, in_eot_reg);
    assign advance    = in_valid_reg && (!closing || out_space);
    assign byte_ready = !in_valid_reg || advance;
    assign take       = byte_valid && byte_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= data_byte;
            in_eot_reg  <= end_of_text;
            in_cap_reg  <= capacity;
        end
    end

    utf8fs_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .data_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .capacity    (in_cap_reg),
        .result      (scan_result)
    );

    utf8fs_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && closing),
        .result      (scan_result),
        .space       (out_space),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .field_data  (out_data)
    );

    assign field_number    = out_data.field_number;
    assign kept_length     = out_data.kept_length;
    assign starts_with_one = out_data.starts_with_one;
    assign number_valid    = out_data.number_valid;
    assign number_value    = out_data.number_value;
    assign last_field      = out_data.last_field;

endmodule

FILE: src/utf8fs_scan.sv
module utf8fs_scan (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               data_byte,
    input  logic                     end_of_text,
    input  logic [8:0]               capacity,
    output utf8fs_pkg::result_t      result
);
    import utf8fs_pkg::*;

    logic [7:0]  byte_position_reg, byte_position_next;
    logic [7:0]  field_limit_reg, field_limit_next;
    logic [7:0]  kept_count_reg, kept_count_next;
    logic [1:0]  pending_reg, pending_next;
    logic        scan_stopped_reg, scan_stopped_next;
    logic        first_is_one_reg, first_is_one_next;
    logic        saw_non_digit_reg, saw_non_digit_next;
    logic [31:0] accum_reg, accum_next;
    logic [7:0]  field_counter_reg, field_counter_next;

    logic [7:0]  limit;
    logic [2:0]  cp_len;
    logic        lead_ok;
    logic        num_ok;

    always_comb
    begin
        byte_position_next = byte_position_reg;
        field_limit_next   = field_limit_reg;
        kept_count_next    = kept_count_reg;
        pending_next       = pending_reg;
        scan_stopped_next  = scan_stopped_reg;
        first_is_one_next  = first_is_one_reg;
        saw_non_digit_next = saw_non_digit_reg;
        accum_next         = accum_reg;
        field_counter_next = field_counter_reg;
        cp_len             = 3'd1;
        lead_ok            = 1'b0;
        // the limit is latched on the first byte, so use it right away there
        limit = (byte_position_reg == 8'd0) ? cap_to_limit(capacity) : field_limit_reg;

        if (step)
        begin
            if (is_close(data_byte, end_of_text))
            begin
                byte_position_next = 8'd0;
                field_limit_next   = 8'd0;
                kept_count_next    = 8'd0;
                pending_next       = 2'd0;
                scan_stopped_next  = 1'b0;
                first_is_one_next  = 1'b0;
                saw_non_digit_next = 1'b0;
                accum_next         = 32'd0;
                if (end_of_text)
                begin
                    field_counter_next = 8'd0;
                end
                else if (field_counter_reg != 8'hFF)
                begin
                    field_counter_next = field_counter_reg + 8'd1;
                end
            end
            else
            begin
                field_limit_next = limit;
                if (byte_position_reg != 8'hFF)
                begin
                    byte_position_next = byte_position_reg + 8'd1;
                end
                if (!scan_stopped_reg && (byte_position_reg < limit))
                begin
                    if (pending_reg != 2'd0)
                    begin
                        if ((data_byte & CONT_MASK) == CONT_CODE)
                        begin
                            pending_next = pending_reg - 2'd1;
                            if (pending_reg == 2'd1)
                            begin
                                kept_count_next    = byte_position_reg + 8'd1;
                                saw_non_digit_next = 1'b1;
                            end
                        end
                        else
                        begin
                            pending_next      = 2'd0;
                            scan_stopped_next = 1'b1;
                        end
                    end
                    else if ((data_byte & ASCII_MASK) == 8'd0)
                    begin
                        kept_count_next = byte_position_reg + 8'd1;
                        if ((byte_position_reg == 8'd0) && (data_byte == ONE_BYTE))
                        begin
                            first_is_one_next = 1'b1;
                        end
                        if ((data_byte >= ZERO_BYTE) && (data_byte <= NINE_BYTE))
                        begin
                            accum_next = (accum_reg << 3) + (accum_reg << 1)
                                       + {28'd0, data_byte[3:0]};
                        end
                        else
                        begin
                            saw_non_digit_next = 1'b1;
                        end
                    end
                    else
                    begin
                        priority if ((data_byte & LEAD2_MASK) == LEAD2_CODE)
                        begin
                            cp_len  = 3'd2;
                            lead_ok = 1'b1;
                        end
                        else if ((data_byte & LEAD3_MASK) == LEAD3_CODE)
                        begin
                            cp_len  = 3'd3;
                            lead_ok = 1'b1;
                        end
                        else if ((data_byte & LEAD4_MASK) == LEAD4_CODE)
                        begin
                            cp_len  = 3'd4;
                            lead_ok = 1'b1;
                        end
                        else
                        begin
                            cp_len  = 3'd1;
                            lead_ok = 1'b0;
                        end
                        // codepoint must fit entirely under the cap
                        if (!lead_ok ||
                            (({1'b0, byte_position_reg} + {6'd0, cp_len}) > {1'b0, limit}))
                        begin
                            scan_stopped_next = 1'b1;
                        end
                        else
                        begin
                            pending_next = 2'(cp_len - 3'd1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            field_limit_reg   <= '0;
            kept_count_reg    <= '0;
            pending_reg       <= '0;
            scan_stopped_reg  <= 1'b0;
            first_is_one_reg  <= 1'b0;
            saw_non_digit_reg <= 1'b0;
            accum_reg         <= '0;
            field_counter_reg <= '0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            field_limit_reg   <= field_limit_next;
            kept_count_reg    <= kept_count_next;
            pending_reg       <= pending_next;
            scan_stopped_reg  <= scan_stopped_next;
            first_is_one_reg  <= first_is_one_next;
            saw_non_digit_reg <= saw_non_digit_next;
            accum_reg         <= accum_next;
            field_counter_reg <= field_counter_next;
        end
    end

    assign num_ok = (kept_count_reg != 8'd0) && !saw_non_digit_reg;

    always_comb
    begin
        result.field_number    = field_counter_reg;
        result.kept_length     = kept_count_reg;
        result.starts_with_one = (kept_count_reg != 8'd0) && first_is_one_reg;
        result.number_valid    = num_ok;
        result.number_value    = num_ok ? accum_reg : 32'd0;
        result.last_field      = end_of_text;
    end

endmodule

FILE: src/utf8fs_out_reg.sv
module utf8fs_out_reg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  utf8fs_pkg::result_t      result,
    output logic                     space,
    output logic                     field_valid,
    input  logic                     field_ready,
    output utf8fs_pkg::result_t      field_data
);
    import utf8fs_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign space = !valid_reg || field_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (field_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign field_valid = valid_reg;
    assign field_data  = data_reg;

endmodule

FILE: src/utf8fs_checker.sv
module utf8fs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_ready,
    input logic        field_valid,
    input logic        field_ready,
    input logic [7:0]  field_number,
    input logic [7:0]  kept_length,
    input logic        starts_with_one,
    input logic        number_valid,
    input logic [31:0] number_value,
    input logic        last_field
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (field_valid && !field_ready) |=> (field_valid && $stable(field_number)
            && $stable(kept_length) && $stable(number_value) && $stable(last_field)))
        else $error("result changed while stalled");

    a_num_len: assert property (@(posedge clk) disable iff (!rst_n)
        (field_valid && (number_valid || starts_with_one)) |-> (kept_length != 8'd0))
        else $error("number or leading one flagged on empty field");

    a_num_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (field_valid && !number_valid) |-> (number_value == 32'd0))
        else $error("number value nonzero without valid number");

    a_reset_out: assert property (@(posedge clk)
        $rose(rst_n) |-> (!field_valid && byte_ready))
        else $error("output valid or input stalled right after reset");

endmodule

bind utf8_safe_field_splitter_core utf8fs_checker u_utf8fs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_ready      (byte_ready),
    .field_valid     (field_valid),
    .field_ready     (field_ready),
    .field_number    (field_number),
    .kept_length     (kept_length),
    .starts_with_one (starts_with_one),
    .number_valid    (number_valid),
    .number_value    (number_value),
    .last_field      (last_field)
);

FILE: sim/utf8_safe_field_splitter_core_test.sv
module utf8_safe_field_splitter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8fs_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
        logic [8:0] cap;
    } text_item_t;

    typedef enum int {FIELD_DIGITS, FIELD_TEXT, FIELD_BROKEN, FIELD_NOISE} field_kind_t;

    // tracks field state per accepted byte and holds the field results still owed
    class field_scoreboard;
        logic [7:0]  scan_pos;
        logic [7:0]  keep_cap;
        logic [7:0]  kept_len;
        logic [1:0]  cont_owed;
        logic        halted;
        logic        first_one;
        logic        has_non_digit;
        logic [31:0] value_acc;
        logic [7:0]  field_idx;
        result_t     pending_fields[$];
        int          mismatches;

        function new();
            reset_field();
            field_idx = '0;
            mismatches = 0;
        endfunction

        function void reset_field();
            scan_pos = '0;
            keep_cap = '0;
            kept_len = '0;
            cont_owed = '0;
            halted = 1'b0;
            first_one = 1'b0;
            has_non_digit = 1'b0;
            value_acc = '0;
        endfunction

        function void note_transfer(text_item_t it);
            result_t r;
            int pos;
            int c;
            int cp_len;
            if (it.eot || it.data == SEP_BYTE)
            begin
                r.field_number = field_idx;
                r.kept_length = kept_len;
                r.starts_with_one = (kept_len != 0) && first_one;
                r.number_valid = (kept_len != 0) && !has_non_digit;
                r.number_value = r.number_valid ? value_acc : '0;
                r.last_field = it.eot;
                pending_fields.push_back(r);
                reset_field();
                if (it.eot)
                    field_idx = '0;
                else if (field_idx != 8'hFF)
                    field_idx++;
                return;
            end
            pos = scan_pos;
            // byte limit is latched from the first data byte of the field
            if (pos == 0)
            begin
                c = (it.cap > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : int'(it.cap);
                c = (c == 0) ? 0 : c - 1;
                keep_cap = (c > 255) ? 8'hFF : 8'(c);
            end
            if (pos < 255)
                scan_pos = 8'(pos + 1);
            if (halted || pos >= keep_cap)
                return;
            if (cont_owed != 0)
            begin
                if ((it.data & CONT_MASK) == CONT_CODE)
                begin
                    cont_owed--;
                    if (cont_owed == 0)
                    begin
                        kept_len = 8'(pos + 1);
                        has_non_digit = 1'b1;
                    end
                end
                else
                begin
                    cont_owed = '0;
                    halted = 1'b1;
                end
                return;
            end
            if ((it.data & ASCII_MASK) == 0)
            begin
                kept_len = 8'(pos + 1);
                if (pos == 0 && it.data == ONE_BYTE)
                    first_one = 1'b1;
                if (it.data >= ZERO_BYTE && it.data <= NINE_BYTE)
                    value_acc = value_acc * 10 + 32'(it.data - ZERO_BYTE);
                else
                    has_non_digit = 1'b1;
                return;
            end
            if ((it.data & LEAD2_MASK) == LEAD2_CODE)
                cp_len = 2;
            else if ((it.data & LEAD3_MASK) == LEAD3_CODE)
                cp_len = 3;
            else if ((it.data & LEAD4_MASK) == LEAD4_CODE)
                cp_len = 4;
            else
            begin
                halted = 1'b1;
                return;
            end
            // a codepoint that would run past the limit ends the scan
            if (pos + cp_len > keep_cap)
            begin
                halted = 1'b1;
                return;
            end
            cont_owed = 2'(cp_len - 1);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t mismatch %s: expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_field(result_t got);
            result_t want;
            if (pending_fields.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected field result, field_number %0d",
                             $time, got.field_number);
                return;
            end
            want = pending_fields.pop_front();
            compare("field_number", want.field_number, got.field_number);
            compare("kept_length", want.kept_length, got.kept_length);
            compare("starts_with_one", want.starts_with_one, got.starts_with_one);
            compare("number_valid", want.number_valid, got.number_valid);
            compare("number_value", want.number_value, got.number_value);
            compare("last_field", want.last_field, got.last_field);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  data_byte = '0;
    logic        end_of_text = 1'b0;
    logic [8:0]  capacity = '0;
    logic        field_valid;
    logic        field_ready = 1'b0;
    logic [7:0]  field_number;
    logic [7:0]  kept_length;
    logic        starts_with_one;
    logic        number_valid;
    logic [31:0] number_value;
    logic        last_field;

    text_item_t      text_q[$];
    field_scoreboard sb;
    logic [7:0]      ready_pat = 8'hFF;
    int              ready_phase = 0;

    utf8_safe_field_splitter_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .data_byte       (data_byte),
        .end_of_text     (end_of_text),
        .capacity        (capacity),
        .field_valid     (field_valid),
        .field_ready     (field_ready),
        .field_number    (field_number),
        .kept_length     (kept_length),
        .starts_with_one (starts_with_one),
        .number_valid    (number_valid),
        .number_value    (number_value),
        .last_field      (last_field)
    );

    always #5 clk = ~clk;

    function automatic void push_item(logic [7:0] data, logic eot, logic [8:0] cap);
        text_item_t it;
        it.data = data;
        it.eot = eot;
        it.cap = cap;
        text_q.push_back(it);
    endfunction

    // mostly the field's own capacity, now and then a stray one
    function automatic void push_byte(logic [7:0] data, logic [8:0] cap);
        if ($urandom_range(0, 7) == 0)
            push_item(data, 1'b0, 9'($urandom));
        else
            push_item(data, 1'b0, cap);
    endfunction

    function automatic logic [8:0] pick_cap();
        case ($urandom_range(0, 5))
            0: return 9'($urandom_range(0, 3));
            1: return 9'($urandom_range(256, 511));
            2: return 9'($urandom_range(0, 511));
            default: return 9'($urandom_range(2, 20));
        endcase
    endfunction

    function automatic field_kind_t pick_kind();
        int w;
        w = $urandom_range(0, 19);
        if (w < 7)
            return FIELD_DIGITS;
        if (w < 14)
            return FIELD_TEXT;
        if (w < 17)
            return FIELD_BROKEN;
        return FIELD_NOISE;
    endfunction

    function automatic void push_codepoint(int cp_len, logic [8:0] cap, bit broken);
        logic [7:0] seq[4];
        int cut;
        int k;
        case (cp_len)
            1: seq[0] = 8'($urandom_range(0, 127));
            2: seq[0] = LEAD2_CODE | 8'($urandom_range(0, 31));
            3: seq[0] = LEAD3_CODE | 8'($urandom_range(0, 15));
            default: seq[0] = LEAD4_CODE | 8'($urandom_range(0, 7));
        endcase
        if (seq[0] == SEP_BYTE)
            seq[0] = ZERO_BYTE;
        for (int i = 1; i < cp_len; i++)
            seq[i] = CONT_CODE | 8'($urandom_range(0, 63));
        cut = cp_len;
        if (broken)
        begin
            if (cp_len > 1 && $urandom_range(0, 1) == 1)
                cut = $urandom_range(1, cp_len - 1);
            else
            begin
                k = $urandom_range(0, cp_len - 1);
                if (k == 0)
                    seq[0] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(128, 191))
                                                        : 8'($urandom_range(248, 255));
                else
                    seq[k] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(192, 255))
                                                        : 8'($urandom_range(48, 57));
            end
        end
        for (int i = 0; i < cut; i++)
            push_byte(seq[i], cap);
    endfunction

    function automatic void add_field(field_kind_t kind, logic [8:0] cap);
        int n;
        case (kind)
            FIELD_DIGITS:
            begin
                n = $urandom_range(0, 14);
                repeat (n) push_byte(8'(ZERO_BYTE + $urandom_range(0, 9)), cap);
            end
            FIELD_TEXT, FIELD_BROKEN:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_codepoint($urandom_range(1, 4), cap,
                                   kind == FIELD_BROKEN && i == n - 1);
            end
            default:
            begin
                n = $urandom_range(0, 8);
                repeat (n) push_byte(8'($urandom), cap);
            end
        endcase
    endfunction

    // output side stalls on a rotating pattern that is redrawn whenever its phase count runs out
    always @(posedge clk)
    begin
        if (field_valid && field_ready)
            sb.check_field('{field_number, kept_length, starts_with_one,
                             number_valid, number_value, last_field});
        if (ready_phase == 0)
        begin
            ready_phase = $urandom_range(16, 96);
            ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end
        ready_phase--;
        ready_pat = {ready_pat[6:0], ready_pat[7]};
        field_ready <= ready_pat[0];
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (byte_valid && byte_ready) || (field_valid && field_ready))
                idle = 0;
            else
                idle++;
        end
        $display("utf8_safe_field_splitter_core_test: errors");
        $finish;
    end

    initial
    begin : main_seq
        int idx;
        int burst_left;
        int gap_left;
        int nf;
        int start;
        logic [8:0] cap;
        bit done;
        sb = new();

        // zero capacity, then capacity of one keeps nothing
        push_item(8'h35, 1'b0, 9'd0);
        push_item(SEP_BYTE, 1'b0, 9'd0);
        push_item(8'h37, 1'b0, 9'd1);
        push_item(SEP_BYTE, 1'b0, 9'd1);
        // digits under an oversized capacity
        push_item(ONE_BYTE, 1'b0, 9'd511);
        push_item(8'h32, 1'b0, 9'd511);
        push_item(8'h33, 1'b0, 9'd511);
        push_item(SEP_BYTE, 1'b0, 9'd511);
        // nul byte is a plain non-digit
        push_item(8'h00, 1'b0, 9'd256);
        push_item(SEP_BYTE, 1'b0, 9'd256);
        push_item(8'hFF, 1'b0, 9'd256);
        push_item(SEP_BYTE, 1'b0, 9'd256);
        // separator in the middle of a codepoint
        push_item(8'hC3, 1'b0, 9'd256);
        push_item(SEP_BYTE, 1'b0, 9'd256);
        push_item(8'hC3, 1'b0, 9'd256);
        push_item(8'h41, 1'b0, 9'd256);
        push_item(SEP_BYTE, 1'b0, 9'd256);
        // three-byte codepoint does not fit a limit of two
        push_item(8'hE2, 1'b0, 9'd3);
        push_item(8'h82, 1'b0, 9'd3);
        push_item(8'hAC, 1'b0, 9'd3);
        push_item(SEP_BYTE, 1'b0, 9'd3);
        push_item(8'hF0, 1'b0, 9'd256);
        push_item(8'h9F, 1'b0, 9'd256);
        push_item(8'h98, 1'b0, 9'd256);
        push_item(8'h80, 1'b0, 9'd256);
        push_item(ONE_BYTE, 1'b0, 9'd256);
        // end marker carrying a separator byte, then an empty last field
        push_item(SEP_BYTE, 1'b1, 9'd256);
        push_item(8'hFF, 1'b1, 9'd0);

        start = text_q.size();
        while (text_q.size() - start < 24)
        begin
            nf = $urandom_range(1, 6);
            for (int f = 0; f < nf; f++)
            begin
                cap = pick_cap();
                add_field(pick_kind(), cap);
                if (f < nf - 1)
                    push_item(SEP_BYTE, 1'b0, cap);
                else
                    push_item(8'($urandom), 1'b1, cap);
            end
        end
        // long payload: field numbers saturate and one field runs past 255 bytes
        for (int f = 0; f < 256; f++)
        begin
            if (f == 100)
            begin
                cap = 9'($urandom_range(256, 511));
                repeat (257) push_item(8'(ZERO_BYTE + $urandom_range(0, 9)), 1'b0, cap);
            end
            else if ($urandom_range(0, 63) == 0)
                add_field(pick_kind(), pick_cap());
            push_item(SEP_BYTE, 1'b0, pick_cap());
        end
        push_item(8'($urandom), 1'b1, pick_cap());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        idx = 0;
        burst_left = $urandom_range(1, 24);
        gap_left = 0;
        done = 1'b0;
        while (!done)
        begin
            @(posedge clk);
            if (byte_valid && byte_ready)
            begin
                sb.note_transfer(text_q[idx]);
                idx++;
            end
            if (!byte_valid || byte_ready)
            begin
                if (idx == text_q.size())
                begin
                    byte_valid <= 1'b0;
                    done = 1'b1;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    byte_valid <= 1'b0;
                end
                else
                begin
                    byte_valid <= 1'b1;
                    data_byte <= text_q[idx].data;
                    end_of_text <= text_q[idx].eot;
                    capacity <= text_q[idx].cap;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end

        while (sb.pending_fields.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_fields.size() == 0)
            $display("utf8_safe_field_splitter_core_test: clean");
        else
            $display("utf8_safe_field_splitter_core_test: errors");
        $finish;
    end

endmodule
